/* hdl/fsamc_pkg.sv */
// Package for the flex sensor averager: widths, register indexes, reset values,
// indicator codes and the structs passed between the map logic and the top level.
// No dependencies.
`timescale 1ns / 1ps

package fsamc_pkg;

    localparam int SAMPLES_PER_MEAN_DEF = 20;
    localparam int SAMPLE_BITS_DEF      = 12;

    localparam int CFG_W     = 12;
    localparam int CFG_IDX_W = 4;
    localparam int ANGLE_W   = 8;
    localparam int MEAN_W    = 16;
    localparam int NUM_W     = 20;
    localparam int IND_W     = 2;

    localparam logic [ANGLE_W-1:0] ANGLE_FULL = 8'd180;
    localparam logic [ANGLE_W-1:0] NO_ANGLE   = 8'd255;

    localparam logic [CFG_IDX_W-1:0] CFG_STRAIGHT = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BENT     = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GREEN    = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_YELLOW   = 4'd3;

    localparam logic [CFG_W-1:0] STRAIGHT_RST = 12'd3000;
    localparam logic [CFG_W-1:0] BENT_RST     = 12'd2723;
    localparam logic [CFG_W-1:0] GREEN_RST    = 12'd2910;
    localparam logic [CFG_W-1:0] YELLOW_RST   = 12'd2790;

    localparam logic [IND_W-1:0] IND_RED    = 2'd0;
    localparam logic [IND_W-1:0] IND_YELLOW = 2'd1;
    localparam logic [IND_W-1:0] IND_GREEN  = 2'd2;

    typedef struct packed {
        logic [CFG_W-1:0] straight_level;
        logic [CFG_W-1:0] bent_level;
        logic [CFG_W-1:0] green_threshold;
        logic [CFG_W-1:0] yellow_threshold;
    } t_cfg;

    typedef struct packed {
        logic             zero_span;
        logic [NUM_W-1:0] numerator;
        logic [CFG_W-1:0] divisor;
        logic [IND_W-1:0] indicator;
    } t_map;

endpackage

/* hdl/fsamc_divider.sv */
// Shared restoring divider, one quotient bit per cycle, unsigned operands.
// Used for both the block mean and the angle map. Depends on nothing.
`timescale 1ns / 1ps

module fsamc_divider #(
    parameter int DVD_W = 20,
    parameter int DVS_W = 12
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DVS_W-1:0] i_divisor,
    output logic             o_done,
    output logic [DVD_W-1:0] o_quotient
);

    localparam int CNT_W = $clog2(DVD_W);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DVS_W-1:0] r_rem;
    logic [DVS_W-1:0] r_dvs;
    logic [DVD_W-1:0] r_quo;

    logic [DVS_W:0]   w_shift;
    logic             w_ge;
    logic [DVS_W-1:0] w_rem_next;

    assign w_shift    = {r_rem, r_quo[DVD_W-1]};
    assign w_ge       = (w_shift >= {1'b0, r_dvs});
    assign w_rem_next = w_ge ? DVS_W'(w_shift - {1'b0, r_dvs}) : w_shift[DVS_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DVD_W - 1);
                r_rem  <= '0;
                r_dvs  <= i_divisor;
                r_quo  <= i_dividend;
            end else if (r_busy) begin
                r_rem <= w_rem_next;
                r_quo <= {r_quo[DVD_W-2:0], w_ge};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

/* hdl/fsamc_map.sv */
// Clamp of the mean to the calibration span, angle numerator and divisor
// magnitudes, and the three-level indicator. Depends on fsamc_pkg.
`timescale 1ns / 1ps

module fsamc_map
    import fsamc_pkg::*;
(
    input  logic [MEAN_W-1:0] i_mean,
    input  t_cfg              i_cfg,
    output t_map              o_map
);

    logic [CFG_W-1:0] w_lo;
    logic [CFG_W-1:0] w_hi;
    logic [CFG_W-1:0] w_clamp;
    logic [CFG_W-1:0] w_dist;
    logic [NUM_W-1:0] w_dist_x;

    always_comb begin
        w_lo = (i_cfg.straight_level < i_cfg.bent_level) ? i_cfg.straight_level
                                                           : i_cfg.bent_level;
        w_hi = (i_cfg.straight_level < i_cfg.bent_level) ? i_cfg.bent_level
                                                           : i_cfg.straight_level;
        if (i_mean < MEAN_W'(w_lo)) begin
            w_clamp = w_lo;
        end else if (i_mean > MEAN_W'(w_hi)) begin
            w_clamp = w_hi;
        end else begin
            w_clamp = i_mean[CFG_W-1:0];
        end

        // clamped value and span lie on the same side of straight, so the
        // quotient is never negative and magnitudes give the truncated result
        w_dist = (w_clamp >= i_cfg.straight_level) ? (w_clamp - i_cfg.straight_level)
                                                   : (i_cfg.straight_level - w_clamp);
        w_dist_x = NUM_W'(w_dist);

        o_map.zero_span = (i_cfg.straight_level == i_cfg.bent_level);
        // times 180 = 128 + 32 + 16 + 4
        o_map.numerator = (w_dist_x << 7) + (w_dist_x << 5) + (w_dist_x << 4)
                        + (w_dist_x << 2);
        o_map.divisor   = w_hi - w_lo;

        if (i_mean >= MEAN_W'(i_cfg.green_threshold)) begin
            o_map.indicator = IND_GREEN;
        end else if (i_mean >= MEAN_W'(i_cfg.yellow_threshold)) begin
            o_map.indicator = IND_YELLOW;
        end else begin
            o_map.indicator = IND_RED;
        end
    end

endmodule

/* hdl/flex_sensor_average_map_classify.sv */
// Top level of the flex sensor averager: sample accumulator, sequencer around
// the shared divider, config registers and output register.
// Depends on fsamc_pkg, fsamc_divider and fsamc_map.
//
// Input channel i_valid / i_sample / o_stall carries one raw ADC sample per item.
// Output channel o_valid / o_* fields / i_stall carries one result per
// SAMPLES_PER_MEAN input items. Config port i_cfg_valid / i_cfg_index /
// i_cfg_data / o_cfg_ready writes straight, bent, green, yellow (index 0..3);
// other indexes are ignored. o_cfg_ready is always high.
// An item that does not close a block is accepted whenever the sequencer is idle. The item that
// closes a block runs the shared divider twice, one quotient bit per cycle over
// DIV_W bits (20 at the defaults): the sum by SAMPLES_PER_MEAN, then the scaled
// offset by the calibration span. The second pass is skipped when the calibration
// levels are equal. o_valid rises once the S_DONE state has loaded the output
// register; o_stall is high from acceptance until then.
// A finished result sits in the output register while the next block
// accumulates; only the item that closes the next block waits for it to be taken.
// Reset clears the sum, count and output valid, loads the default calibration
// and marks the previous angle as absent, so the first result shows a change.
`timescale 1ns / 1ps

module flex_sensor_average_map_classify
    import fsamc_pkg::*;
#(
    parameter int SAMPLES_PER_MEAN = SAMPLES_PER_MEAN_DEF,
    parameter int SAMPLE_BITS      = SAMPLE_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    output logic                   o_stall,
    output logic                   o_valid,
    output logic [CFG_W-1:0]       o_mean_level,
    output logic [ANGLE_W-1:0]     o_bend_angle,
    output logic [ANGLE_W-1:0]     o_servo_command,
    output logic                   o_angle_changed,
    output logic [IND_W-1:0]       o_indicator,
    input  logic                   i_stall,
    input  logic                   i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_W-1:0]       i_cfg_data,
    output logic                   o_cfg_ready
);

    localparam int CNT_W = $clog2(SAMPLES_PER_MEAN + 1);
    localparam int SUM_W = SAMPLE_BITS + CNT_W;
    localparam int DIV_W = (SUM_W > NUM_W) ? SUM_W : NUM_W;
    localparam logic [CNT_W-1:0] LAST_COUNT = CNT_W'(SAMPLES_PER_MEAN - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MEAN,
        S_MAP,
        S_ANGLE,
        S_DONE
    } t_state;

    t_state             r_state;
    t_cfg               r_cfg;
    logic [SUM_W-1:0]   r_sum;
    logic [CNT_W-1:0]   r_count;
    logic [MEAN_W-1:0]  r_mean;
    logic [ANGLE_W-1:0] r_angle;
    logic [ANGLE_W-1:0] r_prev_angle;
    logic               r_div_start;
    logic [DIV_W-1:0]   r_div_dvd;
    logic [CFG_W-1:0]   r_div_dvs;

    logic               r_out_valid;
    logic [CFG_W-1:0]   r_out_mean;
    logic [ANGLE_W-1:0] r_out_angle;
    logic [ANGLE_W-1:0] r_out_servo;
    logic               r_out_changed;
    logic [IND_W-1:0]   r_out_ind;

    logic               w_in_accept;
    logic [SUM_W-1:0]   w_sum_next;
    logic               w_div_done;
    logic [DIV_W-1:0]   w_div_quo;
    t_map               w_map;

    assign o_stall     = !((r_state == S_IDLE) && ((r_count != LAST_COUNT) || !r_out_valid));
    assign w_in_accept = i_valid && !o_stall;
    assign w_sum_next  = r_sum + SUM_W'(i_sample);

    fsamc_divider #(
        .DVD_W (DIV_W),
        .DVS_W (CFG_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_start),
        .i_dividend (r_div_dvd),
        .i_divisor  (r_div_dvs),
        .o_done     (w_div_done),
        .o_quotient (w_div_quo)
    );

    fsamc_map u_map (
        .i_mean (r_mean),
        .i_cfg  (r_cfg),
        .o_map  (w_map)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state                <= S_IDLE;
            r_cfg.straight_level   <= STRAIGHT_RST;
            r_cfg.bent_level       <= BENT_RST;
            r_cfg.green_threshold  <= GREEN_RST;
            r_cfg.yellow_threshold <= YELLOW_RST;
            r_sum                  <= '0;
            r_count                <= '0;
            r_prev_angle           <= NO_ANGLE;
            r_div_start            <= 1'b0;
            r_out_valid            <= 1'b0;
        end else begin
            r_div_start <= 1'b0;

            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_STRAIGHT: r_cfg.straight_level   <= i_cfg_data;
                    CFG_BENT:     r_cfg.bent_level       <= i_cfg_data;
                    CFG_GREEN:    r_cfg.green_threshold  <= i_cfg_data;
                    CFG_YELLOW:   r_cfg.yellow_threshold <= i_cfg_data;
                    default: ;
                endcase
            end

            // drop the result once taken
            if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_in_accept) begin
                        if (r_count == LAST_COUNT) begin
                            r_sum       <= '0;
                            r_count     <= '0;
                            r_div_dvd   <= DIV_W'(w_sum_next);
                            r_div_dvs   <= CFG_W'(SAMPLES_PER_MEAN);
                            r_div_start <= 1'b1;
                            r_state     <= S_MEAN;
                        end else begin
                            r_sum   <= w_sum_next;
                            r_count <= r_count + 1'b1;
                        end
                    end
                end
                S_MEAN: begin
                    if (w_div_done) begin
                        r_mean  <= MEAN_W'(w_div_quo[SAMPLE_BITS-1:0]);
                        r_state <= S_MAP;
                    end
                end
                S_MAP: begin
                    if (w_map.zero_span) begin
                        r_angle <= '0;
                        r_state <= S_DONE;
                    end else begin
                        r_div_dvd   <= DIV_W'(w_map.numerator);
                        r_div_dvs   <= w_map.divisor;
                        r_div_start <= 1'b1;
                        r_state     <= S_ANGLE;
                    end
                end
                S_ANGLE: begin
                    if (w_div_done) begin
                        r_angle <= w_div_quo[ANGLE_W-1:0];
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    r_out_mean    <= r_mean[CFG_W-1:0];
                    r_out_angle   <= r_angle;
                    r_out_servo   <= ANGLE_FULL - r_angle;
                    r_out_changed <= (r_angle != r_prev_angle);
                    r_out_ind     <= w_map.indicator;
                    r_prev_angle  <= r_angle;
                    r_out_valid   <= 1'b1;
                    r_state       <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid         = r_out_valid;
    assign o_mean_level    = r_out_mean;
    assign o_bend_angle    = r_out_angle;
    assign o_servo_command = r_out_servo;
    assign o_angle_changed = r_out_changed;
    assign o_indicator     = r_out_ind;
    assign o_cfg_ready     = 1'b1;

endmodule

/* hdl/fsamc_checker.sv */
// Port-level checker for the flex sensor averager, bound to the top level.
// Depends on fsamc_pkg and flex_sensor_average_map_classify.
`timescale 1ns / 1ps

module fsamc_checker
    import fsamc_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_valid,
    input logic               i_stall,
    input logic [CFG_W-1:0]   o_mean_level,
    input logic [ANGLE_W-1:0] o_bend_angle,
    input logic [ANGLE_W-1:0] o_servo_command,
    input logic               o_angle_changed,
    input logic [IND_W-1:0]   o_indicator
);

    // hold a stalled result
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_mean_level) && $stable(o_bend_angle)
            && $stable(o_servo_command) && $stable(o_angle_changed) && $stable(o_indicator))
        else $error("stalled result changed");

    a_servo_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_bend_angle + o_servo_command) == 9'(ANGLE_FULL))
        else $error("servo command is not the inverted angle");

    a_angle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_bend_angle <= ANGLE_FULL)
        else $error("angle out of range");

    a_ind_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_indicator == IND_RED || o_indicator == IND_YELLOW
            || o_indicator == IND_GREEN))
        else $error("indicator code out of range");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule

bind flex_sensor_average_map_classify fsamc_checker u_fsamc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_valid         (o_valid),
    .i_stall         (i_stall),
    .o_mean_level    (o_mean_level),
    .o_bend_angle    (o_bend_angle),
    .o_servo_command (o_servo_command),
    .o_angle_changed (o_angle_changed),
    .o_indicator     (o_indicator)
);
